>>> rtl/wrp_pkg.sv
`default_nettype none

package wrp_pkg;

  // Chunk ids as they collect in the shift register, first byte in the low lane
  localparam logic [31:0] ID_RIFF = 32'h4646_4952;
  localparam logic [31:0] ID_WAVE = 32'h4556_4157;
  localparam logic [31:0] ID_FMT  = 32'h2074_6D66;
  localparam logic [31:0] ID_FACT = 32'h7463_6166;
  localparam logic [31:0] ID_DATA = 32'h6174_6164;

  localparam logic [2:0] ST_OK       = 3'd0;
  localparam logic [2:0] ST_NOT_RIFF = 3'd1;
  localparam logic [2:0] ST_NOT_WAVE = 3'd2;
  localparam logic [2:0] ST_FORMAT   = 3'd3;
  localparam logic [2:0] ST_END      = 3'd4;

  // Accepted fmt format codes
  localparam logic [15:0] TAG_PCM   = 16'd1;
  localparam logic [15:0] TAG_FLOAT = 16'd3;
  localparam logic [15:0] TAG_ALAW  = 16'd6;
  localparam logic [15:0] TAG_MULAW = 16'd7;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       end_of_stream;
  } wrp_in_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [15:0] audio_format;
    logic [15:0] channel_count;
    logic [31:0] sample_rate_hz;
    logic [31:0] bytes_per_second;
    logic [15:0] frame_bytes;
    logic [15:0] sample_bits;
    logic [31:0] fact_length;
    logic [31:0] payload_bytes;
    logic [31:0] payload_offset;
  } wrp_out_t;

endpackage

`default_nettype wire

>>> rtl/wrp_parser.sv
`default_nettype none

module wrp_parser (
  input  logic             clk,
  input  logic             rst,
  input  logic             take,
  input  wrp_pkg::wrp_in_t item,
  output logic             res_valid,
  output wrp_pkg::wrp_out_t res
);
  import wrp_pkg::*;

  typedef enum logic [3:0] {
    PH_RIFF, PH_RSIZE, PH_WAVE, PH_CID, PH_CSIZE, PH_FMT, PH_FACT, PH_SKIP, PH_DONE
  } phase_t;

  phase_t       phase, phase_next;
  logic [31:0]  cnt, cnt_next;
  logic [31:0]  id_shift, id_shift_next;
  logic [31:0]  chunk_length, chunk_length_next;
  logic [127:0] fmt_fields, fmt_fields_next;
  logic [31:0]  fact_value, fact_value_next;
  logic [31:0]  file_offset, file_offset_next;
  logic         result_given, result_given_next;

  logic        give;
  logic [2:0]  give_status;
  logic [31:0] pbytes;
  logic [31:0] poff;
  logic [31:0] cnt1;
  logic [31:0] id_sh;
  logic [31:0] len_sh;
  logic [31:0] fo_inc;

  function automatic logic tag_ok(input logic [15:0] t);
    return t inside {TAG_PCM, TAG_FLOAT, TAG_ALAW, TAG_MULAW};
  endfunction

  always_comb begin
    phase_next        = phase;
    cnt_next          = cnt;
    id_shift_next     = id_shift;
    chunk_length_next = chunk_length;
    fmt_fields_next   = fmt_fields;
    fact_value_next   = fact_value;
    file_offset_next  = file_offset;
    result_given_next = result_given;
    give              = 1'b0;
    give_status       = ST_OK;
    pbytes            = '0;
    poff              = '0;
    cnt1   = cnt + 32'd1;
    id_sh  = {item.data_byte, id_shift[31:8]};
    len_sh = {item.data_byte, chunk_length[31:8]};
    fo_inc = (file_offset == 32'hFFFF_FFFF) ? file_offset : file_offset + 32'd1;

    if (item.end_of_stream) begin
      give        = !result_given;
      give_status = ST_END;
    end else if (!result_given) begin
      file_offset_next = fo_inc;
      case (phase)
        PH_RIFF, PH_WAVE, PH_CID: begin
          id_shift_next = id_sh;
          cnt_next      = cnt1;
          if (|cnt1[31:2]) begin
            cnt_next = '0;
            if (phase == PH_RIFF) begin
              phase_next = PH_RSIZE;
            end else if (phase == PH_CID) begin
              phase_next = PH_CSIZE;
            end else if (id_sh != ID_WAVE) begin
              give        = 1'b1;
              give_status = ST_NOT_WAVE;
            end else begin
              phase_next = PH_CID;
            end
          end
        end
        PH_RSIZE, PH_CSIZE: begin
          chunk_length_next = len_sh;
          cnt_next          = cnt1;
          if (|cnt1[31:2]) begin
            cnt_next = '0;
            if (phase == PH_RSIZE) begin
              if (id_shift != ID_RIFF) begin
                give        = 1'b1;
                give_status = ST_NOT_RIFF;
              end else begin
                phase_next = PH_WAVE;
              end
            end else if (id_shift == ID_DATA) begin
              give        = 1'b1;
              give_status = ST_OK;
              pbytes      = len_sh;
              poff        = fo_inc;
            end else if (id_shift == ID_FMT) begin
              if (len_sh == 32'd0) begin
                // empty body: check the tag held from before
                if (!tag_ok(fmt_fields[15:0])) begin
                  give        = 1'b1;
                  give_status = ST_FORMAT;
                end else begin
                  phase_next = PH_CID;
                end
              end else begin
                phase_next = PH_FMT;
              end
            end else if (len_sh == 32'd0) begin
              phase_next = PH_CID;
            end else if (id_shift == ID_FACT) begin
              phase_next = PH_FACT;
            end else begin
              phase_next = PH_SKIP;
            end
          end
        end
        PH_FMT: begin
          if (cnt < 32'd16) begin
            fmt_fields_next[{cnt[3:0], 3'b000} +: 8] = item.data_byte;
          end
          cnt_next = cnt1;
          if (cnt1 == chunk_length) begin
            if (!tag_ok(fmt_fields_next[15:0])) begin
              give        = 1'b1;
              give_status = ST_FORMAT;
            end else begin
              phase_next = PH_CID;
              cnt_next   = '0;
            end
          end
        end
        PH_FACT: begin
          if (cnt < 32'd4) begin
            fact_value_next[{cnt[1:0], 3'b000} +: 8] = item.data_byte;
          end
          cnt_next = cnt1;
          if (cnt1 == chunk_length) begin
            cnt_next   = '0;
            phase_next = PH_CID;
          end
        end
        PH_SKIP: begin
          cnt_next = cnt1;
          if (cnt1 == chunk_length) begin
            cnt_next   = '0;
            phase_next = PH_CID;
          end
        end
        default: ;
      endcase
      if (give) begin
        result_given_next = 1'b1;
        phase_next        = PH_DONE;
      end
    end

    res_valid            = give;
    res.status           = give_status;
    res.audio_format     = fmt_fields_next[15:0];
    res.channel_count    = fmt_fields_next[31:16];
    res.sample_rate_hz   = fmt_fields_next[63:32];
    res.bytes_per_second = fmt_fields_next[95:64];
    res.frame_bytes      = fmt_fields_next[111:96];
    res.sample_bits      = fmt_fields_next[127:112];
    res.fact_length      = fact_value_next;
    res.payload_bytes    = pbytes;
    res.payload_offset   = poff;
  end

  always_ff @(posedge clk) begin
    if (rst || (take && item.end_of_stream)) begin
      // end marker rearms the parser exactly as reset does
      phase        <= PH_RIFF;
      cnt          <= '0;
      id_shift     <= '0;
      chunk_length <= '0;
      fmt_fields   <= '0;
      fact_value   <= '0;
      file_offset  <= '0;
      result_given <= 1'b0;
    end else if (take) begin
      phase        <= phase_next;
      cnt          <= cnt_next;
      id_shift     <= id_shift_next;
      chunk_length <= chunk_length_next;
      fmt_fields   <= fmt_fields_next;
      fact_value   <= fact_value_next;
      file_offset  <= file_offset_next;
      result_given <= result_given_next;
    end
  end

  a_eos_rearms: assert property (@(posedge clk) disable iff (rst)
    take && item.end_of_stream |=> phase == PH_RIFF && !result_given && file_offset == 32'd0)
    else $error("end marker did not rearm the parser");

  a_given_done: assert property (@(posedge clk) disable iff (rst)
    result_given |-> phase == PH_DONE)
    else $error("result given but parser not in done phase");

  a_one_result: assert property (@(posedge clk) disable iff (rst)
    take && res_valid && !item.end_of_stream |=> result_given)
    else $error("result issued without marking it given");

  a_err_zero: assert property (@(posedge clk) disable iff (rst)
    res_valid && res.status != ST_OK |-> res.payload_bytes == 32'd0 && res.payload_offset == 32'd0)
    else $error("error result carries payload fields");

endmodule

`default_nettype wire

>>> rtl/wrp_out_fifo.sv
`default_nettype none

module wrp_out_fifo (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  input  wrp_pkg::wrp_out_t push_item,
  output logic              full,
  output logic              pop_valid,
  input  logic              pop_ready,
  output wrp_pkg::wrp_out_t pop_item
);
  import wrp_pkg::*;

  wrp_out_t   mem [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;
  logic       pop;

  assign full      = (count == 2'd2);
  assign pop_valid = (count != 2'd0);
  assign pop       = pop_valid && pop_ready;
  assign pop_item  = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= !wr_ptr;
      end
      if (pop) begin
        rd_ptr <= !rd_ptr;
      end
      count <= count + {1'b0, push} - {1'b0, pop};
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    push |-> !full)
    else $error("result pushed into full queue");

  a_count_range: assert property (@(posedge clk) disable iff (rst)
    count != 2'd3)
    else $error("queue count out of range");

  a_count_hold: assert property (@(posedge clk) disable iff (rst)
    !push && !pop |=> count == $past(count))
    else $error("queue count moved without push or pop");

endmodule

`default_nettype wire

>>> rtl/wav_riff_header_parser.sv
`default_nettype none
// RIFF/WAVE header parser.
// src channel: one request per file byte (src_item.data_byte), or an end
// marker (src_item.end_of_stream = 1) that carries no byte, closes the file
// and rearms the parser for the next one.
// hdr channel: at most one header result per file: status, the fmt and fact
// fields captured so far, and on success the data chunk size and offset.
// Throughput: one request per cycle while src_ready is high; every byte only
// updates the phase, counters and shift registers in a single registered step.
// Results: a result is pushed into the two-entry result queue when the request
// that caused it is accepted, and hdr_valid is registered from the queue.
// Bytes after a result are taken and dropped until the end marker.
// Stall: while hdr_ready is low the queue holds up to two results; src_ready
// drops only when both entries are full.
// Reset: synchronous; clears the queue and returns the parser to the
// preamble phase with all captured fields at zero.
module wav_riff_header_parser (
  input  logic              clk,
  input  logic              rst,
  input  logic              src_valid,
  output logic              src_ready,
  input  wrp_pkg::wrp_in_t  src_item,
  output logic              hdr_valid,
  input  logic              hdr_ready,
  output wrp_pkg::wrp_out_t hdr_item
);
  import wrp_pkg::*;

  logic     take;
  logic     res_valid;
  wrp_out_t res;
  logic     full;

  assign src_ready = !full;
  assign take      = src_valid && src_ready;

  wrp_parser u_parser (
    .clk       (clk),
    .rst       (rst),
    .take      (take),
    .item      (src_item),
    .res_valid (res_valid),
    .res       (res)
  );

  wrp_out_fifo u_out_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (take && res_valid),
    .push_item (res),
    .full      (full),
    .pop_valid (hdr_valid),
    .pop_ready (hdr_ready),
    .pop_item  (hdr_item)
  );

endmodule

`default_nettype wire

>>> dv/wrp_check_pkg.sv
`default_nettype none

package wrp_check_pkg;
  import wrp_pkg::*;

  localparam int MAX_PRINTED = 40;

  typedef enum logic [3:0] {
    PH_RIFF, PH_RSIZE, PH_WAVE, PH_CID, PH_CSIZE, PH_FMT, PH_FACT, PH_SKIP, PH_DONE
  } parse_phase_e;

  class header_scoreboard;
    parse_phase_e phase;
    logic [31:0]  byte_count;
    logic [31:0]  id_shift;
    logic [31:0]  chunk_len;
    logic [63:0]  fmt_word [2];
    logic [31:0]  fact_len;
    logic [31:0]  file_pos;
    bit           header_given;
    wrp_out_t     expected_headers [$];
    int           errors;
    int           per_status [5];

    function new();
      errors = 0;
      foreach (per_status[i]) per_status[i] = 0;
      expected_headers.delete();
      clear();
    endfunction

    function void clear();
      phase        = PH_RIFF;
      byte_count   = '0;
      id_shift     = '0;
      chunk_len    = '0;
      fmt_word[0]  = '0;
      fmt_word[1]  = '0;
      fact_len     = '0;
      file_pos     = '0;
      header_given = 1'b0;
    endfunction

    function int pending();
      return expected_headers.size();
    endfunction

    function void post(logic [2:0] st, logic [31:0] pbytes, logic [31:0] poff);
      wrp_out_t e;
      e.status           = st;
      e.audio_format     = fmt_word[0][15:0];
      e.channel_count    = fmt_word[0][31:16];
      e.sample_rate_hz   = fmt_word[0][63:32];
      e.bytes_per_second = fmt_word[1][31:0];
      e.frame_bytes      = fmt_word[1][47:32];
      e.sample_bits      = fmt_word[1][63:48];
      e.fact_length      = fact_len;
      e.payload_bytes    = pbytes;
      e.payload_offset   = poff;
      expected_headers.push_back(e);
      header_given = 1'b1;
      phase = PH_DONE;
    endfunction

    function void close_fmt();
      logic [15:0] tag;
      tag = fmt_word[0][15:0];
      if (tag == TAG_PCM || tag == TAG_FLOAT || tag == TAG_ALAW || tag == TAG_MULAW) begin
        phase = PH_CID;
        byte_count = '0;
      end else begin
        post(ST_FORMAT, '0, '0);
      end
    endfunction

    function void note_request(wrp_in_t req);
      logic [7:0] b;
      b = req.data_byte;
      if (req.end_of_stream) begin
        if (!header_given) post(ST_END, '0, '0);
        clear();
        return;
      end
      if (header_given) return;
      if (file_pos != 32'hFFFF_FFFF) file_pos++;
      case (phase)
        PH_RIFF, PH_WAVE, PH_CID: begin
          id_shift = {b, id_shift[31:8]};
          byte_count++;
          if (byte_count >= 4) begin
            byte_count = '0;
            if (phase == PH_RIFF) phase = PH_RSIZE;
            else if (phase == PH_CID) phase = PH_CSIZE;
            else if (id_shift != ID_WAVE) post(ST_NOT_WAVE, '0, '0);
            else phase = PH_CID;
          end
        end
        PH_RSIZE, PH_CSIZE: begin
          chunk_len = {b, chunk_len[31:8]};
          byte_count++;
          if (byte_count >= 4) begin
            byte_count = '0;
            if (phase == PH_RSIZE) begin
              if (id_shift != ID_RIFF) post(ST_NOT_RIFF, '0, '0);
              else phase = PH_WAVE;
            end else if (id_shift == ID_DATA) begin
              post(ST_OK, chunk_len, file_pos);
            end else if (id_shift == ID_FMT) begin
              if (chunk_len == 0) close_fmt();
              else phase = PH_FMT;
            end else if (chunk_len == 0) begin
              phase = PH_CID;
            end else begin
              phase = (id_shift == ID_FACT) ? PH_FACT : PH_SKIP;
            end
          end
        end
        PH_FMT: begin
          if (byte_count < 16) fmt_word[byte_count[3]][byte_count[2:0]*8 +: 8] = b;
          byte_count++;
          if (byte_count == chunk_len) close_fmt();
        end
        PH_FACT, PH_SKIP: begin
          if (phase == PH_FACT && byte_count < 4) fact_len[byte_count[1:0]*8 +: 8] = b;
          byte_count++;
          if (byte_count == chunk_len) begin
            byte_count = '0;
            phase = PH_CID;
          end
        end
        default: ;
      endcase
    endfunction

    task report(string msg);
      if (errors < MAX_PRINTED) $display("MISMATCH: %s", msg);
      errors++;
    endtask

    task compare_field(string name, logic [31:0] got, logic [31:0] want);
      if (got !== want) report($sformatf("%s got %0h, want %0h", name, got, want));
    endtask

    task check_header(wrp_out_t got);
      wrp_out_t e;
      if (expected_headers.size() == 0) begin
        report($sformatf("header with status %0d arrived with none outstanding", got.status));
        return;
      end
      e = expected_headers.pop_front();
      if (e.status <= ST_END) per_status[e.status]++;
      compare_field("status", got.status, e.status);
      compare_field("audio_format", got.audio_format, e.audio_format);
      compare_field("channel_count", got.channel_count, e.channel_count);
      compare_field("sample_rate_hz", got.sample_rate_hz, e.sample_rate_hz);
      compare_field("bytes_per_second", got.bytes_per_second, e.bytes_per_second);
      compare_field("frame_bytes", got.frame_bytes, e.frame_bytes);
      compare_field("sample_bits", got.sample_bits, e.sample_bits);
      compare_field("fact_length", got.fact_length, e.fact_length);
      compare_field("payload_bytes", got.payload_bytes, e.payload_bytes);
      compare_field("payload_offset", got.payload_offset, e.payload_offset);
    endtask
  endclass

endpackage

`default_nettype wire

>>> dv/testbench.sv
`default_nettype none

module testbench;
  import wrp_pkg::*;
  import wrp_check_pkg::*;

  localparam int TARGET_REQUESTS = 1200;
  localparam int CALM_FROM       = 1030;
  localparam int HOLD_CYCLES     = 150;
  localparam int IDLE_LIMIT      = 2000;
  localparam int DRAIN_CYCLES    = 8;

  logic     clk = 1'b0;
  logic     rst = 1'b1;
  logic     src_valid = 1'b0;
  logic     src_ready;
  wrp_in_t  src_item = '0;
  logic     hdr_valid;
  logic     hdr_ready = 1'b0;
  wrp_out_t hdr_item;

  header_scoreboard headers;
  logic [7:0] file_bytes [$];
  int  sent = 0;
  int  files = 0;
  bit  calm = 1'b0;
  bit  hold_req = 1'b0;

  wav_riff_header_parser dut (
    .clk       (clk),
    .rst       (rst),
    .src_valid (src_valid),
    .src_ready (src_ready),
    .src_item  (src_item),
    .hdr_valid (hdr_valid),
    .hdr_ready (hdr_ready),
    .hdr_item  (hdr_item)
  );

  initial begin
    forever #10 clk = ~clk;
  end

  initial begin
    headers = new();
  end

  // Offer one request and hold it until taken.
  task automatic offer(input wrp_in_t req);
    if (!calm && $urandom_range(0, 11) == 0) begin
      src_valid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk);
    end
    src_valid <= 1'b1;
    src_item  <= req;
    do @(posedge clk); while (!src_ready);
    headers.note_request(req);
    sent++;
  endtask

  task automatic offer_end();
    wrp_in_t req;
    req.data_byte     = 8'($urandom);
    req.end_of_stream = 1'b1;
    offer(req);
  endtask

  function automatic void add_le32(logic [31:0] w);
    for (int i = 0; i < 4; i++) file_bytes.push_back(w[i*8 +: 8]);
  endfunction

  function automatic void add_random(int n);
    repeat (n) file_bytes.push_back(8'($urandom));
  endfunction

  task automatic play_file();
    wrp_in_t req;
    foreach (file_bytes[i]) begin
      req.data_byte     = file_bytes[i];
      req.end_of_stream = 1'b0;
      offer(req);
    end
    offer_end();
    file_bytes.delete();
    files++;
  endtask

  function automatic void build_random_file();
    int dice, kind, sz, cut;
    bit stop;
    logic [15:0] tag;
    logic [15:0] known_tags [4];
    known_tags = '{TAG_PCM, TAG_FLOAT, TAG_ALAW, TAG_MULAW};
    stop = 1'b0;
    dice = $urandom_range(0, 99);
    file_bytes.delete();
    if (dice < 12) begin
      add_random($urandom_range(0, 14));
      return;
    end
    add_le32(ID_RIFF);
    add_le32($urandom);
    add_le32(ID_WAVE);
    repeat ($urandom_range(0, 3)) begin
      if (stop) break;
      kind = $urandom_range(0, 9);
      if (kind <= 3) begin
        cut = $urandom_range(0, 99);
        sz = (cut < 60) ? 16 : (cut < 75) ? 18 : $urandom_range(0, 17);
        tag = ($urandom_range(0, 4) != 0) ? known_tags[$urandom_range(0, 3)] : 16'($urandom);
        add_le32(ID_FMT);
        add_le32(sz);
        for (int i = 0; i < sz; i++)
          file_bytes.push_back(i < 2 ? tag[i*8 +: 8] : 8'($urandom));
      end else if (kind <= 5) begin
        sz = ($urandom_range(0, 4) < 3) ? 4 : $urandom_range(0, 7);
        add_le32(ID_FACT);
        add_le32(sz);
        add_random(sz);
      end else if (kind <= 8) begin
        sz = $urandom_range(0, 6);
        add_le32($urandom);
        add_le32(sz);
        add_random(sz);
      end else begin
        // oversized chunk: the file ends inside its body
        add_le32($urandom);
        add_le32($urandom | 32'h8000_0000);
        add_random($urandom_range(0, 4));
        stop = 1'b1;
      end
    end
    if (!stop && $urandom_range(0, 9) < 8) begin
      add_le32(ID_DATA);
      add_le32($urandom);
      add_random($urandom_range(0, 3));
    end
    if (dice < 24)
      file_bytes[$urandom_range(0, 11)] ^= 8'(1 << $urandom_range(0, 7));
    if ($urandom_range(0, 9) == 0 && file_bytes.size() > 0) begin
      cut = $urandom_range(0, file_bytes.size() - 1);
      while (file_bytes.size() > cut) void'(file_bytes.pop_back());
    end
  endfunction

  // Stimulus
  initial begin
    bit held, paused;
    held = 1'b0;
    paused = 1'b0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // end marker on a fresh parser
    offer_end();
    files++;
    // bad RIFF id with all-ones size, then a dropped byte
    add_le32(32'h5846_4952);
    add_le32(32'hFFFF_FFFF);
    file_bytes.push_back(8'h00);
    play_file();
    // shortest good file: data chunk straight after the preamble
    add_le32(ID_RIFF);
    add_le32(32'h0000_0000);
    add_le32(ID_WAVE);
    add_le32(ID_DATA);
    add_le32(32'hFFFF_FFFF);
    file_bytes.push_back(8'hFF);
    play_file();

    while (sent < TARGET_REQUESTS) begin
      if (!held && sent >= 400) begin
        // stall the result side and keep pushing end markers at it
        held = 1'b1;
        hold_req = 1'b1;
        repeat (12) begin
          offer_end();
          files++;
        end
      end
      if (!paused && sent >= 750) begin
        paused = 1'b1;
        src_valid <= 1'b0;
        do @(posedge clk); while (headers.pending() != 0);
      end
      if (sent >= CALM_FROM) calm = 1'b1;
      build_random_file();
      play_file();
    end
    src_valid <= 1'b0;

    do @(posedge clk); while (headers.pending() != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Sent %0d requests over %0d files, with a long result stall and a full drain.",
             sent, files);
    $display("Headers: ok %0d, not RIFF %0d, not WAVE %0d, bad tag %0d, early end %0d.",
             headers.per_status[ST_OK], headers.per_status[ST_NOT_RIFF],
             headers.per_status[ST_NOT_WAVE], headers.per_status[ST_FORMAT],
             headers.per_status[ST_END]);
    if (headers.errors == 0) begin
      $display("wav_riff_header_parser regression: pass");
    end else begin
      $display("wav_riff_header_parser regression: fail");
    end
    $finish;
  end

  // Result side: random back-pressure, plus one long hold when asked
  initial begin
    @(negedge rst);
    forever begin
      if (hold_req) begin
        hdr_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_req = 1'b0;
      end else if (!calm && $urandom_range(0, 9) == 0) begin
        hdr_ready <= 1'b0;
        repeat ($urandom_range(1, 3)) @(posedge clk);
      end else begin
        hdr_ready <= 1'b1;
        @(posedge clk);
      end
    end
  end

  always @(posedge clk) begin
    if (!rst && hdr_valid && hdr_ready) headers.check_header(hdr_item);
  end

  initial begin
    int idle;
    idle = 0;
    forever begin
      @(posedge clk);
      if (rst || (src_valid && src_ready) || (hdr_valid && hdr_ready)) idle = 0;
      else idle++;
      if (idle >= IDLE_LIMIT) begin
        $display("Timed out after %0d cycles with nothing accepted.", idle);
        $display("wav_riff_header_parser regression: fail");
        $finish;
      end
    end
  end

endmodule

`default_nettype wire
